[rtl/table_slot_grid_former_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the table slot grid former
// Clocked assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef TABLE_SLOT_GRID_FORMER_MACROS_SVH
`define TABLE_SLOT_GRID_FORMER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TSGF_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("table slot grid former check failed");

// A condition that must hold in the cycle after a trigger.
`define TSGF_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("table slot grid former check failed");

`endif

[rtl/tsgf_pkg.sv]
// ----------------------------------------------------------------------------
// tsgf_pkg
// Shared constants, codes and helpers of the table slot grid former.
// ----------------------------------------------------------------------------
`default_nettype none

package tsgf_pkg;

  localparam int DEF_MAX_COLUMNS = 64;
  localparam int DEF_MAX_ROWS    = 256;
  localparam int DEF_MAX_GROWING = 16;

  localparam logic [2:0] CMD_ADD_COLS   = 3'd0;
  localparam logic [2:0] CMD_BEGIN_ROW  = 3'd1;
  localparam logic [2:0] CMD_PLACE_CELL = 3'd2;
  localparam logic [2:0] CMD_END_ROW    = 3'd3;
  localparam logic [2:0] CMD_END_GROUP  = 3'd4;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_CLAMP   = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Bits lo .. hi-1 set; anything at or above 64 falls off the top.
  function automatic logic [63:0] span_mask(input logic [7:0] lo, input logic [7:0] hi);
    logic [63:0] m;
    for (int i = 0; i < 64; i++) begin
      m[i] = (8'(i) >= lo) && (8'(i) < hi);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/table_slot_grid_former.sv]
// ----------------------------------------------------------------------------
// table_slot_grid_former
// Builds a table's slot grid of occupancy bits from a stream of commands.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on the in_ channel (in_cmd, in_row_span,
// in_col_span) and exactly one result beat leaves on the out_ channel with
// the anchor of a placed cell, the grid size after the command and a status.
// Commands are handled one at a time; in_ready is high only while the
// sequencer is idle. Add columns, end row and unknown commands pass from the
// execute state straight to done; begin row and end row group sweep through
// the rows they touch first, and place cell scans its row for a free slot
// before its sweep, since every touched grid row is a read-modify-write
// through the single row memory at one row per cycle. The sequencer is idle
// again, ready for the next command, from the edge that loads a result.
// After reset the row memory is cleared one row per cycle, with in_ready
// held low. A result waits in the output register while out_ready is low;
// the next command is still accepted and finishes up to its result, which
// then waits until the earlier one has left.
// ----------------------------------------------------------------------------
`default_nettype none

module table_slot_grid_former #(
  parameter int MAX_COLUMNS = tsgf_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = tsgf_pkg::DEF_MAX_ROWS,
  parameter int MAX_GROWING = tsgf_pkg::DEF_MAX_GROWING
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_cmd,
  input  wire logic [8:0] in_row_span,
  input  wire logic [6:0] in_col_span,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [5:0]      out_anchor_col,
  output logic [7:0]      out_anchor_row,
  output logic [6:0]      out_width_now,
  output logic [8:0]      out_height_now,
  output logic [1:0]      out_status
);

  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int RW  = $clog2(MAX_ROWS + 1);
  localparam int AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int GW  = $clog2(MAX_GROWING + 1);
  localparam int ERW = ((RW > 9) ? RW : 9) + 1;

  tsgf_pkg::state_t state_r, state_nxt;

  logic [2:0]             cmd_r, cmd_nxt;
  logic [8:0]             rs_r, rs_nxt;
  logic [6:0]             cs_r, cs_nxt;
  logic [CW-1:0]          grid_cols_r, grid_cols_nxt;
  logic [RW-1:0]          grid_rows_r, grid_rows_nxt;
  logic [CW-1:0]          cursor_col_r, cursor_col_nxt;
  logic [RW-1:0]          cursor_row_r, cursor_row_nxt;
  logic [MAX_COLUMNS-1:0] grow_mask_r, grow_mask_nxt;
  logic [GW-1:0]          grow_cnt_r, grow_cnt_nxt;
  logic [5:0]             acol_r, acol_nxt;
  logic [7:0]             arow_r, arow_nxt;
  logic [1:0]             stat_r, stat_nxt;
  logic [RW-1:0]          sw_addr_r, sw_addr_nxt;
  logic [RW-1:0]          sw_end_r, sw_end_nxt;
  logic [MAX_COLUMNS-1:0] sw_mask_r, sw_mask_nxt;
  logic                   wb_pend_r, wb_pend_nxt;
  logic [AW-1:0]          wb_addr_r, wb_addr_nxt;
  logic [AW-1:0]          clr_addr_r, clr_addr_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             o_acol_r, o_acol_nxt;
  logic [7:0]             o_arow_r, o_arow_nxt;
  logic [6:0]             o_width_r, o_width_nxt;
  logic [8:0]             o_height_r, o_height_nxt;
  logic [1:0]             o_stat_r, o_stat_nxt;

  logic                   mem_rd_en;
  logic [AW-1:0]          mem_rd_addr;
  logic [MAX_COLUMNS-1:0] mem_rd_data;
  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [MAX_COLUMNS-1:0] mem_wr_data;

  tsgf_row_mem #(
    .DEPTH (MAX_ROWS),
    .WIDTH (MAX_COLUMNS),
    .AW    (AW)
  ) u_row_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  always_comb begin
    logic [7:0]     w8;
    logic [CW-1:0]  first_free;
    logic [CW-1:0]  new_col;
    logic [CW-1:0]  gc;
    logic [6:0]     csp;
    logic [8:0]     rsp;
    logic [7:0]     end_col;
    logic [ERW-1:0] end_row;
    logic [RW-1:0]  row_lim;
    logic [MAX_COLUMNS-1:0] cell_mask;

    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    rs_nxt         = rs_r;
    cs_nxt         = cs_r;
    grid_cols_nxt  = grid_cols_r;
    grid_rows_nxt  = grid_rows_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    grow_mask_nxt  = grow_mask_r;
    grow_cnt_nxt   = grow_cnt_r;
    acol_nxt       = acol_r;
    arow_nxt       = arow_r;
    stat_nxt       = stat_r;
    sw_addr_nxt    = sw_addr_r;
    sw_end_nxt     = sw_end_r;
    sw_mask_nxt    = sw_mask_r;
    wb_pend_nxt    = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    clr_addr_nxt   = clr_addr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_acol_nxt     = o_acol_r;
    o_arow_nxt     = o_arow_r;
    o_width_nxt    = o_width_r;
    o_height_nxt   = o_height_r;
    o_stat_nxt     = o_stat_r;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = cursor_row_r[AW-1:0];
    mem_wr_en      = 1'b0;
    mem_wr_addr    = wb_addr_r;
    mem_wr_data    = mem_rd_data | sw_mask_r;
    in_ready       = 1'b0;

    w8         = '0;
    first_free = CW'(MAX_COLUMNS);
    new_col    = '0;
    gc         = grid_cols_r;
    csp        = '0;
    rsp        = '0;
    end_col    = '0;
    end_row    = '0;
    row_lim    = '0;
    cell_mask  = '0;

    case (state_r)
      tsgf_pkg::ST_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_ROWS - 1)) begin
          state_nxt = tsgf_pkg::ST_IDLE;
        end
      end

      tsgf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          rs_nxt    = in_row_span;
          cs_nxt    = in_col_span;
          acol_nxt  = '0;
          arow_nxt  = '0;
          stat_nxt  = tsgf_pkg::STAT_OK;
          state_nxt = tsgf_pkg::ST_EXEC;
        end
      end

      tsgf_pkg::ST_EXEC: begin
        state_nxt = tsgf_pkg::ST_DONE;
        case (cmd_r)
          tsgf_pkg::CMD_ADD_COLS: begin
            w8 = 8'(grid_cols_r) + 8'(cs_r);
            if (w8 > 8'(MAX_COLUMNS)) begin
              w8       = 8'(MAX_COLUMNS);
              stat_nxt = tsgf_pkg::STAT_CLAMP;
            end
            grid_cols_nxt = CW'(w8);
          end
          tsgf_pkg::CMD_BEGIN_ROW: begin
            cursor_col_nxt = '0;
            if (cursor_row_r >= RW'(MAX_ROWS)) begin
              stat_nxt = tsgf_pkg::STAT_CLAMP;
            end else begin
              if (grid_rows_r <= cursor_row_r) begin
                grid_rows_nxt = cursor_row_r + 1'b1;
              end
              sw_addr_nxt = cursor_row_r;
              sw_end_nxt  = cursor_row_r + 1'b1;
              sw_mask_nxt = grow_mask_r;
              state_nxt   = tsgf_pkg::ST_SWEEP;
            end
          end
          tsgf_pkg::CMD_PLACE_CELL: begin
            if (cursor_row_r >= RW'(MAX_ROWS)) begin
              stat_nxt = tsgf_pkg::STAT_CLAMP;
            end else begin
              mem_rd_en = 1'b1;
              state_nxt = tsgf_pkg::ST_SCAN;
            end
          end
          tsgf_pkg::CMD_END_ROW: begin
            if (cursor_row_r < RW'(MAX_ROWS)) begin
              cursor_row_nxt = cursor_row_r + 1'b1;
            end
          end
          tsgf_pkg::CMD_END_GROUP: begin
            row_lim = (grid_rows_r < RW'(MAX_ROWS)) ? grid_rows_r : RW'(MAX_ROWS);
            sw_addr_nxt = cursor_row_r;
            sw_end_nxt  = row_lim;
            sw_mask_nxt = grow_mask_r;
            if (cursor_row_r < row_lim) begin
              cursor_row_nxt = row_lim;
            end
            // The growing list empties once, after every remaining row has it.
            grow_mask_nxt = '0;
            grow_cnt_nxt  = '0;
            state_nxt     = tsgf_pkg::ST_SWEEP;
          end
          default: begin
            stat_nxt = tsgf_pkg::STAT_UNKNOWN;
          end
        endcase
      end

      tsgf_pkg::ST_SCAN: begin
        // First free slot at or after the cursor, bounded by the grid width.
        for (int i = MAX_COLUMNS - 1; i >= 0; i--) begin
          if ((CW'(i) >= cursor_col_r) && !mem_rd_data[i]) begin
            first_free = CW'(i);
          end
        end
        if (cursor_col_r < grid_cols_r) begin
          new_col = (first_free < grid_cols_r) ? first_free : grid_cols_r;
        end else begin
          new_col = cursor_col_r;
        end
        if (new_col == gc) begin
          if (gc < CW'(MAX_COLUMNS)) begin
            gc = gc + 1'b1;
          end else begin
            stat_nxt = tsgf_pkg::STAT_CLAMP;
          end
        end
        cursor_col_nxt = new_col;
        state_nxt      = tsgf_pkg::ST_DONE;
        if (new_col < CW'(MAX_COLUMNS)) begin
          csp     = (cs_r == 7'd0) ? 7'd1 : cs_r;
          rsp     = (rs_r == 9'd0) ? 9'd1 : rs_r;
          end_col = 8'(new_col) + 8'(csp);
          if (end_col > 8'(MAX_COLUMNS)) begin
            end_col  = 8'(MAX_COLUMNS);
            stat_nxt = tsgf_pkg::STAT_CLAMP;
          end
          if (8'(gc) < end_col) begin
            gc = CW'(end_col);
          end
          end_row = ERW'(cursor_row_r) + ERW'(rsp);
          if (end_row > ERW'(MAX_ROWS)) begin
            end_row  = ERW'(MAX_ROWS);
            stat_nxt = tsgf_pkg::STAT_CLAMP;
          end
          if (ERW'(grid_rows_r) < end_row) begin
            grid_rows_nxt = RW'(end_row);
          end
          cell_mask = MAX_COLUMNS'(tsgf_pkg::span_mask(8'(new_col), end_col));
          if (rs_r == 9'd0) begin
            if (grow_cnt_r < GW'(MAX_GROWING)) begin
              grow_mask_nxt = grow_mask_r | cell_mask;
              grow_cnt_nxt  = grow_cnt_r + 1'b1;
            end else begin
              stat_nxt = tsgf_pkg::STAT_CLAMP;
            end
          end
          acol_nxt       = 6'(new_col);
          arow_nxt       = 8'(cursor_row_r);
          cursor_col_nxt = CW'(end_col);
          sw_addr_nxt    = cursor_row_r;
          sw_end_nxt     = RW'(end_row);
          sw_mask_nxt    = cell_mask;
          state_nxt      = tsgf_pkg::ST_SWEEP;
        end else begin
          stat_nxt = tsgf_pkg::STAT_CLAMP;
        end
        grid_cols_nxt = gc;
      end

      tsgf_pkg::ST_SWEEP: begin
        // Reads run one row ahead of the write-backs, so no row is read
        // while its own update is still pending.
        mem_wr_en = wb_pend_r;
        if (sw_addr_r < sw_end_r) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = sw_addr_r[AW-1:0];
          sw_addr_nxt = sw_addr_r + 1'b1;
          wb_pend_nxt = 1'b1;
          wb_addr_nxt = sw_addr_r[AW-1:0];
        end else if (!wb_pend_r) begin
          state_nxt = tsgf_pkg::ST_DONE;
        end
      end

      tsgf_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_acol_nxt    = acol_r;
          o_arow_nxt    = arow_r;
          o_width_nxt   = 7'(grid_cols_r);
          o_height_nxt  = 9'(grid_rows_r);
          o_stat_nxt    = stat_r;
          state_nxt     = tsgf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tsgf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tsgf_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      grid_cols_r  <= '0;
      grid_rows_r  <= '0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      grow_mask_r  <= '0;
      grow_cnt_r   <= '0;
      wb_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      grid_cols_r  <= grid_cols_nxt;
      grid_rows_r  <= grid_rows_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      grow_mask_r  <= grow_mask_nxt;
      grow_cnt_r   <= grow_cnt_nxt;
      wb_pend_r    <= wb_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rs_r       <= rs_nxt;
    cs_r       <= cs_nxt;
    acol_r     <= acol_nxt;
    arow_r     <= arow_nxt;
    stat_r     <= stat_nxt;
    sw_addr_r  <= sw_addr_nxt;
    sw_end_r   <= sw_end_nxt;
    sw_mask_r  <= sw_mask_nxt;
    wb_addr_r  <= wb_addr_nxt;
    o_acol_r   <= o_acol_nxt;
    o_arow_r   <= o_arow_nxt;
    o_width_r  <= o_width_nxt;
    o_height_r <= o_height_nxt;
    o_stat_r   <= o_stat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_anchor_col = o_acol_r;
  assign out_anchor_row = o_arow_r;
  assign out_width_now  = o_width_r;
  assign out_height_now = o_height_r;
  assign out_status     = o_stat_r;

endmodule

`default_nettype wire

[rtl/tsgf_row_mem.sv]
// ----------------------------------------------------------------------------
// tsgf_row_mem
// Occupancy row memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgf_row_mem #(
  parameter int DEPTH = tsgf_pkg::DEF_MAX_ROWS,
  parameter int WIDTH = tsgf_pkg::DEF_MAX_COLUMNS,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/tsgf_checker.sv]
// ----------------------------------------------------------------------------
// tsgf_checker
// Port-level checks of the table slot grid former, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "table_slot_grid_former_macros.svh"

module tsgf_port_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] out_anchor_col,
  input wire logic [7:0] out_anchor_row,
  input wire logic [6:0] out_width_now,
  input wire logic [1:0] out_status
);

  // A waiting result beat keeps its status.
  `TSGF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status))

  // Commands are taken one at a time.
  `TSGF_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  `TSGF_ASSERT(a_status_code, !out_valid || (out_status != 2'd3))

  // An unknown command never carries an anchor.
  `TSGF_ASSERT(a_unknown_no_anchor,
    !(out_valid && (out_status == tsgf_pkg::STAT_UNKNOWN)) ||
    ((out_anchor_col == 6'd0) && (out_anchor_row == 8'd0)))

  `TSGF_ASSERT(a_width_bound, !out_valid || (out_width_now <= 7'(tsgf_pkg::DEF_MAX_COLUMNS)))

endmodule

bind table_slot_grid_former tsgf_port_checker u_tsgf_checker (.*);

`default_nettype wire

[bench/tsgf_checker.sv]
// ----------------------------------------------------------------------------
// Slot grid former result checker
// Watches both channels of the grid former and keeps its own copy of the
// occupancy grid, cursors and growing-cell list. Every accepted command beat
// yields one predicted result, and each result beat is compared with the
// oldest prediction field by field.
// ----------------------------------------------------------------------------
module tsgf_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [8:0] in_row_span,
  input  logic [6:0] in_col_span,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [5:0] out_anchor_col,
  input  logic [7:0] out_anchor_row,
  input  logic [6:0] out_width_now,
  input  logic [8:0] out_height_now,
  input  logic [1:0] out_status,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = tsgf_pkg::DEF_MAX_COLUMNS;
  localparam int ROWS = tsgf_pkg::DEF_MAX_ROWS;
  localparam int GROW = tsgf_pkg::DEF_MAX_GROWING;

  typedef struct packed {
    logic [5:0] anchor_col;
    logic [7:0] anchor_row;
    logic [6:0] width_now;
    logic [8:0] height_now;
    logic [1:0] status;
  } grid_result_t;

  logic [63:0]  occupied [ROWS];
  int           width_cols, height_rows, col_pos, row_pos, grow_n;
  int           grow_lo [GROW];
  int           grow_w [GROW];
  grid_result_t expected_results [$];

  function automatic logic [63:0] cols_between(int lo, int hi);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 64; i++) m[i] = (i >= lo) && (i < hi);
    return m;
  endfunction

  function automatic void extend_growing(int row);
    if (row >= ROWS) return;
    for (int i = 0; i < grow_n; i++)
      occupied[row] |= cols_between(grow_lo[i], grow_lo[i] + grow_w[i]);
  endfunction

  function automatic grid_result_t form_grid(logic [2:0] cmd, int rs, int cs);
    grid_result_t res;
    int acol, arow, end_c, end_r;
    logic [1:0] st;
    bit grows;
    acol = 0; arow = 0; st = tsgf_pkg::STAT_OK;
    case (cmd)
      tsgf_pkg::CMD_ADD_COLS: begin
        width_cols += cs;
        if (width_cols > COLS) begin
          width_cols = COLS;
          st = tsgf_pkg::STAT_CLAMP;
        end
      end
      tsgf_pkg::CMD_BEGIN_ROW: begin
        col_pos = 0;
        if (row_pos >= ROWS) st = tsgf_pkg::STAT_CLAMP;
        else begin
          if (height_rows <= row_pos) height_rows = row_pos + 1;
          extend_growing(row_pos);
        end
      end
      tsgf_pkg::CMD_PLACE_CELL: begin
        if (row_pos >= ROWS) st = tsgf_pkg::STAT_CLAMP;
        else begin
          grows = (rs == 0);
          while (col_pos < width_cols && col_pos < 64 && occupied[row_pos][col_pos])
            col_pos++;
          if (col_pos == width_cols) begin
            if (width_cols < COLS) width_cols++;
            else st = tsgf_pkg::STAT_CLAMP;
          end
          if (col_pos >= COLS) st = tsgf_pkg::STAT_CLAMP;
          else begin
            if (grows) rs = 1;
            if (cs == 0) cs = 1;
            end_c = col_pos + cs;
            if (end_c > COLS) begin
              end_c = COLS;
              st = tsgf_pkg::STAT_CLAMP;
            end
            if (width_cols < end_c) width_cols = end_c;
            end_r = row_pos + rs;
            if (end_r > ROWS) begin
              end_r = ROWS;
              st = tsgf_pkg::STAT_CLAMP;
            end
            if (height_rows < end_r) height_rows = end_r;
            for (int r = row_pos; r < end_r; r++) occupied[r] |= cols_between(col_pos, end_c);
            if (grows) begin
              if (grow_n < GROW) begin
                grow_lo[grow_n] = col_pos;
                grow_w[grow_n] = end_c - col_pos;
                grow_n++;
              end else st = tsgf_pkg::STAT_CLAMP;
            end
            acol = col_pos;
            arow = row_pos;
            col_pos = end_c;
          end
        end
      end
      tsgf_pkg::CMD_END_ROW: if (row_pos < ROWS) row_pos++;
      tsgf_pkg::CMD_END_GROUP: begin
        while (row_pos < height_rows && row_pos < ROWS) begin
          extend_growing(row_pos);
          row_pos++;
        end
        grow_n = 0;
      end
      default: st = tsgf_pkg::STAT_UNKNOWN;
    endcase
    res.anchor_col = 6'(acol);
    res.anchor_row = 8'(arow);
    res.width_now  = 7'(width_cols);
    res.height_now = 9'(height_rows);
    res.status     = st;
    return res;
  endfunction

  always @(posedge clk) begin
    grid_result_t want, got;
    if (!rst_n) begin
      for (int r = 0; r < ROWS; r++) occupied[r] = '0;
      width_cols = 0; height_rows = 0; col_pos = 0; row_pos = 0; grow_n = 0;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(form_grid(in_cmd, int'(in_row_span), int'(in_col_span)));
      if (out_valid && out_ready) begin
        got = {out_anchor_col, out_anchor_row, out_width_now, out_height_now, out_status};
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.anchor_col !== want.anchor_col)
            $display("%0t: anchor_col expected %0d actual %0d", $time, want.anchor_col,
                     got.anchor_col);
          if (got.anchor_row !== want.anchor_row)
            $display("%0t: anchor_row expected %0d actual %0d", $time, want.anchor_row,
                     got.anchor_row);
          if (got.width_now !== want.width_now)
            $display("%0t: width_now expected %0d actual %0d", $time, want.width_now,
                     got.width_now);
          if (got.height_now !== want.height_now)
            $display("%0t: height_now expected %0d actual %0d", $time, want.height_now,
                     got.height_now);
          if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          if (got !== want) fail_count++;
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

[bench/tb_table_slot_grid_former.sv]
// ----------------------------------------------------------------------------
// Slot grid former testbench
// Drives directed and random table command streams with random gaps on both
// sides and a long receiver hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_table_slot_grid_former;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  logic [2:0] in_cmd;
  logic [8:0] in_row_span;
  logic [6:0] in_col_span;
  logic [5:0] out_anchor_col;
  logic [7:0] out_anchor_row;
  logic [6:0] out_width_now;
  logic [8:0] out_height_now;
  logic [1:0] out_status;
  int         fail_count, pending;
  bit         calm_phase, hold_off;

  table_slot_grid_former DUT (.*);

  tsgf_checker scoreboard (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: random stalls, one long hold-off, and calm stretches.
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      out_ready <= calm_phase || ($urandom_range(99) >= 34);
    end
  end

  task automatic send_beat(logic [2:0] cmd, logic [8:0] rs, logic [6:0] cs);
    while (!calm_phase && $urandom_range(99) < 34) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid    <= 1;
    in_cmd      <= cmd;
    in_row_span <= rs;
    in_col_span <= cs;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [8:0] pick_rows();
    case ($urandom_range(9))
      0: return 9'd0;
      1: return 9'($urandom_range(511));
      2: return 9'd256;
      default: return 9'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic logic [6:0] pick_cols();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'($urandom_range(127));
      2: return 7'd64;
      default: return 7'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    int n;
    in_valid = 0; in_cmd = tsgf_pkg::CMD_ADD_COLS; in_row_span = 0; in_col_span = 0;
    calm_phase = 0; hold_off = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: extremes, every command, unknown codes, overflows.
    send_beat(tsgf_pkg::CMD_ADD_COLS, 9'h1FF, 7'd0);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd1, 7'd1);
    send_beat(tsgf_pkg::CMD_BEGIN_ROW, 9'd0, 7'd0);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd0, 7'd2);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd2, 7'd0);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd1, 7'h7F);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd1, 7'd1);
    send_beat(tsgf_pkg::CMD_END_ROW, 9'd0, 7'd0);
    send_beat(tsgf_pkg::CMD_BEGIN_ROW, 9'd0, 7'd0);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd300, 7'd3);
    send_beat(tsgf_pkg::CMD_ADD_COLS, 9'd0, 7'h7F);
    send_beat(3'd5, 9'h1FF, 7'h7F);
    send_beat(3'd6, 9'd0, 7'd0);
    send_beat(3'd7, 9'h155, 7'h2A);
    send_beat(tsgf_pkg::CMD_END_GROUP, 9'd0, 7'd0);
    send_beat(tsgf_pkg::CMD_BEGIN_ROW, 9'd0, 7'd0);
    for (int i = 0; i < 17; i++) send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd0, 7'd1);
    send_beat(tsgf_pkg::CMD_END_GROUP, 9'd0, 7'd0);
    for (int i = 0; i < 260; i++) send_beat(tsgf_pkg::CMD_END_ROW, 9'd0, 7'd0);
    send_beat(tsgf_pkg::CMD_BEGIN_ROW, 9'd0, 7'd0);
    send_beat(tsgf_pkg::CMD_PLACE_CELL, 9'd1, 7'd1);
    send_beat(tsgf_pkg::CMD_END_GROUP, 9'd0, 7'd0);

    // Random table bodies; the grid fills toward its limits as they go.
    n = 0;
    while (n < 300) begin
      if (n == 50) hold_off = 1;
      calm_phase = (n >= 150 && n < 230);
      if ($urandom_range(19) == 0) begin
        send_beat(3'($urandom_range(7)), 9'($urandom), 7'($urandom));
        n++;
      end else begin
        if ($urandom_range(4) == 0) begin
          send_beat(tsgf_pkg::CMD_ADD_COLS, 9'($urandom), pick_cols());
          n++;
        end
        for (int r = $urandom_range(1, 4); r > 0; r--) begin
          send_beat(tsgf_pkg::CMD_BEGIN_ROW, 9'($urandom), 7'($urandom));
          for (int c = $urandom_range(0, 5); c > 0; c--) begin
            send_beat(tsgf_pkg::CMD_PLACE_CELL, pick_rows(), pick_cols());
            n++;
          end
          send_beat(tsgf_pkg::CMD_END_ROW, 9'($urandom), 7'($urandom));
          n += 2;
        end
        send_beat(tsgf_pkg::CMD_END_GROUP, 9'($urandom), 7'($urandom));
        n++;
      end
    end
    in_valid <= 0;
    calm_phase = 1;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
